// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, codes and controller/datapath interface types for the
// four-channel scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

    // channel count and fixed-point formats
    localparam int CHANNELS      = 4;
    localparam int EST_FRAC_BITS = 16;
    localparam int VAR_FRAC_BITS = 28;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEAS_W  = 32;
    localparam int EST_W   = MEAS_W + EST_FRAC_BITS;
    localparam int DIFF_W  = EST_W + 1;
    localparam int VAR_W   = 32;
    localparam int DEN_W   = VAR_W + 1;
    localparam int K_W     = VAR_FRAC_BITS + 1;
    localparam int NUM_W   = VAR_W + VAR_FRAC_BITS + 1;
    localparam int LO_W    = 32;
    localparam int HI_W    = EST_W - LO_W;
    localparam int PLO_W   = K_W + LO_W;
    localparam int PHI_W   = K_W + HI_W;
    localparam int PVAR_W  = K_W + VAR_W;
    localparam int CORR_W  = PHI_W + LO_W + 1;
    localparam int CNT_W   = $clog2(K_W);

    // stream and configuration port widths
    localparam int COURSE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int MODE_W   = 2;
    localparam int DATA_W   = 4 * MEAS_W + COURSE_W + STAMP_W;
    localparam int NUM_REGS = 8;
    localparam int CFG_AW   = 3;
    localparam int CFG_W    = 32;

    localparam logic [K_W-1:0] K_ONE = K_W'(1) << VAR_FRAC_BITS;
    localparam logic [VAR_W-1:0] VAR_ONE = VAR_W'(1) << VAR_FRAC_BITS;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        32'd2684, 32'd26844, 32'd2684, 32'd26844,
        32'd26843546, 32'd268435456, 32'd134217728, 32'd536870912
    };

    // request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_UPDATE = 2'd0,
        MODE_SET    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_DSTART,
        ST_DWAIT,
        ST_KSEL,
        ST_MLO,
        ST_MHI,
        ST_COMMIT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic            in_load;
        logic            clr_all;
        logic            set_all;
        logic            ch_load;
        logic            div_start;
        logic            k_sel;
        logic            mul_lo;
        logic            mul_hi;
        logic            commit;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  primed;
        logic  den_zero;
        logic  div_done;
        logic  div_busy;
        logic  out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider for the Kalman gain, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [skf_pkg::NUM_W-1:0]   num,
    input  wire logic [skf_pkg::DEN_W-1:0]   den,
    output logic                             busy,
    output logic                             done,
    output logic [skf_pkg::K_W-1:0]          quot
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [skf_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [skf_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [skf_pkg::K_W-1:0]       bits_reg, bits_next;
    logic [skf_pkg::K_W-1:0]       quot_reg, quot_next;
    logic [skf_pkg::DEN_W:0]       trial;
    logic [skf_pkg::DEN_W:0]       diff;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, bits_reg[skf_pkg::K_W-1]};
    assign diff  = trial - {1'b0, den};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = skf_pkg::DEN_W'(num[skf_pkg::NUM_W-1:skf_pkg::K_W]);
            bits_next = num[skf_pkg::K_W-1:0];
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            bits_next = {bits_reg[skf_pkg::K_W-2:0], 1'b0};
            if (!diff[skf_pkg::DEN_W])
            begin
                rem_next  = diff[skf_pkg::DEN_W-1:0];
                quot_next = {quot_reg[skf_pkg::K_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[skf_pkg::DEN_W-1:0];
                quot_next = {quot_reg[skf_pkg::K_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == skf_pkg::CNT_W'(skf_pkg::K_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/skf_dp.sv =====
// ----------------------------------------------------------------------------
// skf_dp
// Datapath: filter state, noise registers, gain and update arithmetic,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire skf_pkg::cmd_t                 cmd,
    output skf_pkg::stat_t                     stat,
    input  wire logic [skf_pkg::MODE_W-1:0]    s_tuser,
    input  wire logic [skf_pkg::DATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [skf_pkg::DATA_W-1:0]         m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [skf_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [skf_pkg::CFG_W-1:0]     cfg_data
);

    logic [skf_pkg::MEAS_W-1:0]   meas_reg [skf_pkg::CHANNELS];
    logic [skf_pkg::COURSE_W-1:0] course_reg;
    logic [skf_pkg::STAMP_W-1:0]  stamp_reg;
    skf_pkg::mode_t               mode_reg;

    logic [skf_pkg::EST_W-1:0]    est_reg [skf_pkg::CHANNELS];
    logic [skf_pkg::VAR_W-1:0]    var_reg [skf_pkg::CHANNELS];
    logic [skf_pkg::CHANNELS-1:0] primed_reg;
    logic [skf_pkg::CFG_W-1:0]    cfg_reg [skf_pkg::NUM_REGS];

    logic [skf_pkg::VAR_W-1:0]    pp_reg;
    logic [skf_pkg::DEN_W-1:0]    den_reg;
    logic [skf_pkg::EST_W-1:0]    mag_reg;
    logic                         neg_reg;
    logic [skf_pkg::K_W-1:0]      k_reg;
    logic [skf_pkg::PLO_W-1:0]    plo_reg;
    logic [skf_pkg::PHI_W-1:0]    phi_reg;
    logic [skf_pkg::PVAR_W-1:0]   pvar_reg;
    logic                         out_valid_reg;
    logic [skf_pkg::DATA_W-1:0]   out_data_reg;

    logic [skf_pkg::CFG_W-1:0]    q_cur, r_cur;
    logic [skf_pkg::VAR_W:0]      pp_sum;
    logic [skf_pkg::VAR_W-1:0]    pp_sat;
    logic [skf_pkg::DEN_W-1:0]    den_cur;
    logic [skf_pkg::EST_W-1:0]    m_fix, x_cur;
    logic [skf_pkg::DIFF_W-1:0]   diff, diff_abs;
    logic [skf_pkg::NUM_W-1:0]    div_num;
    logic [skf_pkg::K_W-1:0]      quot;
    logic                         div_busy, div_done;
    logic [skf_pkg::CORR_W-1:0]   corr_sum;
    logic [skf_pkg::EST_W-1:0]    corr;
    logic [skf_pkg::EST_W-1:0]    x_new;
    logic [skf_pkg::PVAR_W-1:0]   pvar_sum;
    logic [skf_pkg::DATA_W-1:0]   out_pack;

    // operands of the selected channel
    assign q_cur   = cfg_reg[{cmd.ch, 1'b0}];
    assign r_cur   = cfg_reg[{cmd.ch, 1'b1}];
    assign pp_sum  = {1'b0, var_reg[cmd.ch]} + {1'b0, q_cur};
    assign pp_sat  = pp_sum[skf_pkg::VAR_W] ? '1 : pp_sum[skf_pkg::VAR_W-1:0];
    assign den_cur = {1'b0, pp_sat} + {1'b0, r_cur};
    assign m_fix   = {meas_reg[cmd.ch], {skf_pkg::EST_FRAC_BITS{1'b0}}};
    assign x_cur   = est_reg[cmd.ch];
    assign diff    = {m_fix[skf_pkg::EST_W-1], m_fix} - {x_cur[skf_pkg::EST_W-1], x_cur};
    assign diff_abs = diff[skf_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;

    // gain numerator pp * one + den / 2
    assign div_num = {1'b0, pp_reg, {skf_pkg::VAR_FRAC_BITS{1'b0}}}
                   + skf_pkg::NUM_W'(den_reg >> 1);

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    // correction rounded half away from zero
    assign corr_sum = {phi_reg, {skf_pkg::LO_W{1'b0}}} + skf_pkg::CORR_W'(plo_reg)
                    + (skf_pkg::CORR_W'(1) << (skf_pkg::VAR_FRAC_BITS - 1));
    assign corr     = corr_sum[skf_pkg::EST_W+skf_pkg::VAR_FRAC_BITS-1:skf_pkg::VAR_FRAC_BITS];
    assign x_new    = neg_reg ? (x_cur - corr) : (x_cur + corr);
    assign pvar_sum = pvar_reg + (skf_pkg::PVAR_W'(1) << (skf_pkg::VAR_FRAC_BITS - 1));

    // rounded estimates and pass-through fields
    always_comb
    begin
        logic [skf_pkg::EST_W-1:0] rnd;
        out_pack = '0;
        for (int c = 0; c < skf_pkg::CHANNELS; c++)
        begin
            rnd = est_reg[c] + (skf_pkg::EST_W'(1) << (skf_pkg::EST_FRAC_BITS - 1));
            out_pack[c*skf_pkg::MEAS_W +: skf_pkg::MEAS_W] =
                rnd[skf_pkg::EST_W-1:skf_pkg::EST_FRAC_BITS];
        end
        out_pack[4*skf_pkg::MEAS_W +: skf_pkg::COURSE_W] = course_reg;
        out_pack[4*skf_pkg::MEAS_W+skf_pkg::COURSE_W +: skf_pkg::STAMP_W] = stamp_reg;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            for (int c = 0; c < skf_pkg::CHANNELS; c++)
            begin
                meas_reg[c] <= s_tdata[c*skf_pkg::MEAS_W +: skf_pkg::MEAS_W];
            end
            course_reg <= s_tdata[4*skf_pkg::MEAS_W +: skf_pkg::COURSE_W];
            stamp_reg  <= s_tdata[4*skf_pkg::MEAS_W+skf_pkg::COURSE_W +: skf_pkg::STAMP_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= skf_pkg::MODE_NONE;
        end
        else if (cmd.in_load)
        begin
            mode_reg <= skf_pkg::mode_t'(s_tuser);
        end
    end

    // noise registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < skf_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= skf_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < skf_pkg::CHANNELS; c++)
            begin
                est_reg[c] <= '0;
                var_reg[c] <= skf_pkg::VAR_ONE;
            end
            primed_reg <= '0;
        end
        else if (cmd.clr_all)
        begin
            for (int c = 0; c < skf_pkg::CHANNELS; c++)
            begin
                est_reg[c] <= '0;
                var_reg[c] <= skf_pkg::VAR_ONE;
            end
            primed_reg <= '0;
        end
        else if (cmd.set_all)
        begin
            for (int c = 0; c < skf_pkg::CHANNELS; c++)
            begin
                est_reg[c] <= {meas_reg[c], {skf_pkg::EST_FRAC_BITS{1'b0}}};
            end
            primed_reg <= '1;
        end
        else if (cmd.commit)
        begin
            if (primed_reg[cmd.ch])
            begin
                est_reg[cmd.ch] <= x_new;
                var_reg[cmd.ch] <= pvar_sum[skf_pkg::VAR_W+skf_pkg::VAR_FRAC_BITS-1:
                                            skf_pkg::VAR_FRAC_BITS];
            end
            else
            begin
                est_reg[cmd.ch] <= m_fix;
                var_reg[cmd.ch] <= skf_pkg::VAR_ONE;
                primed_reg[cmd.ch] <= 1'b1;
            end
        end
    end

    // gain and products
    always_ff @(posedge clk)
    begin
        if (cmd.ch_load)
        begin
            pp_reg  <= pp_sat;
            den_reg <= den_cur;
            neg_reg <= diff[skf_pkg::DIFF_W-1];
            mag_reg <= diff_abs[skf_pkg::EST_W-1:0];
        end
        if (cmd.k_sel)
        begin
            k_reg <= (den_reg == '0) ? skf_pkg::K_ONE : quot;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= skf_pkg::PLO_W'(k_reg) * skf_pkg::PLO_W'(mag_reg[skf_pkg::LO_W-1:0]);
        end
        if (cmd.mul_hi)
        begin
            phi_reg  <= skf_pkg::PHI_W'(k_reg)
                      * skf_pkg::PHI_W'(mag_reg[skf_pkg::EST_W-1:skf_pkg::LO_W]);
            pvar_reg <= skf_pkg::PVAR_W'(skf_pkg::K_ONE - k_reg) * skf_pkg::PVAR_W'(pp_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= out_pack;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat.mode     = mode_reg;
    assign stat.primed   = primed_reg[cmd.ch];
    assign stat.den_zero = (den_reg == '0);
    assign stat.div_done = div_done;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

// ===== rtl/skf_ctrl.sv =====
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer: decodes a request and, for an update, walks the channels through gain,
// products and state write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire skf_pkg::stat_t    stat,
    output skf_pkg::cmd_t          cmd
);

    skf_pkg::state_t             state_reg, state_next;
    logic [skf_pkg::CH_W-1:0]    ch_reg, ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::ST_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = skf_pkg::ST_DECODE;
                end
            end
            skf_pkg::ST_DECODE:
            begin
                ch_next = '0;
                unique case (stat.mode)
                    skf_pkg::MODE_UPDATE: state_next = skf_pkg::ST_LOAD;
                    skf_pkg::MODE_SET:
                    begin
                        cmd.set_all = 1'b1;
                        state_next  = skf_pkg::ST_IDLE;
                    end
                    skf_pkg::MODE_CLEAR:
                    begin
                        cmd.clr_all = 1'b1;
                        state_next  = skf_pkg::ST_IDLE;
                    end
                    default: state_next = skf_pkg::ST_IDLE;
                endcase
            end
            skf_pkg::ST_LOAD:
            begin
                cmd.ch_load = 1'b1;
                state_next  = stat.primed ? skf_pkg::ST_DSTART : skf_pkg::ST_COMMIT;
            end
            skf_pkg::ST_DSTART:
            begin
                cmd.div_start = !stat.den_zero;
                state_next    = stat.den_zero ? skf_pkg::ST_KSEL : skf_pkg::ST_DWAIT;
            end
            skf_pkg::ST_DWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = skf_pkg::ST_KSEL;
                end
            end
            skf_pkg::ST_KSEL:
            begin
                cmd.k_sel  = 1'b1;
                state_next = skf_pkg::ST_MLO;
            end
            skf_pkg::ST_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = skf_pkg::ST_MHI;
            end
            skf_pkg::ST_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = skf_pkg::ST_COMMIT;
            end
            skf_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (ch_reg == skf_pkg::CH_W'(skf_pkg::CHANNELS - 1))
                begin
                    state_next = skf_pkg::ST_OUT;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = skf_pkg::ST_LOAD;
                end
            end
            skf_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = skf_pkg::ST_IDLE;
                end
            end
            default: state_next = skf_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_four_channel_top.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_four_channel_top
// Four scalar random-walk Kalman filters sharing one gain divider.
// ----------------------------------------------------------------------------
// update request: the 4 channels in turn, each through the bit-serial gain
// divider unless unprimed or with a zero denominator
// set and clear requests skip the channel walk; one request in flight at a time
// result sits in an output register, so the next request is taken while it waits
// reset: estimates zero, variances one, channels unprimed, noise registers
// at their defaults; no clearing pass
`default_nettype none

module scalar_kalman_four_channel_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // lat_in, lon_in, alt_in, speed_in, course_in, stamp_in
    input  wire logic [skf_pkg::DATA_W-1:0]    s_tdata,
    // mode
    input  wire logic [skf_pkg::MODE_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // lat_est, lon_est, alt_est, speed_est, course_out, stamp_out
    output logic [skf_pkg::DATA_W-1:0]         m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [skf_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [skf_pkg::CFG_W-1:0]     cfg_data
);

    skf_pkg::cmd_t  cmd;
    skf_pkg::stat_t stat;

    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // one request in flight
    a_single_request : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    // a pending result is never overwritten
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register loaded while holding an untaken result");

    // state write-back never overlaps the divider
    a_commit_idle_div : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !stat.div_busy)
        else $error("channel committed while gain division still running");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-channel scalar Kalman filter: requests of
// every kind go in over the slave stream, a fixed-point filter bank in the
// bench predicts each result and the master stream is checked against it,
// over several noise settings and idling patterns.
// ----------------------------------------------------------------------------

// filter bank prediction and result store
class kalman_scoreboard;
    typedef logic [skf_pkg::DATA_W-1:0] word_t;

    word_t       pending_results[$];
    int          errors;
    logic [31:0] noise_reg [skf_pkg::NUM_REGS];
    longint      est_x [4];
    logic [31:0] est_p [4];
    bit          primed [4];

    function new();
        errors = 0;
        foreach (noise_reg[i]) noise_reg[i] = skf_pkg::CFG_RESET[i];
        clear_filters();
    endfunction

    function void clear_filters();
        for (int c = 0; c < 4; c++)
        begin
            est_x[c]  = 0;
            est_p[c]  = skf_pkg::VAR_ONE;
            primed[c] = 0;
        end
    endfunction

    function void write_reg(int idx, logic [31:0] val);
        noise_reg[idx] = val;
    endfunction

    // one predict and correct step on a channel
    function void filter_channel(int c, longint m);
        logic [63:0]  pp, den, k, mag, one_v;
        logic [127:0] prod;
        longint       d, corr;
        one_v = 64'd1 << skf_pkg::VAR_FRAC_BITS;
        if (!primed[c])
        begin
            est_x[c]  = m;
            est_p[c]  = skf_pkg::VAR_ONE;
            primed[c] = 1;
            return;
        end
        pp = 64'(est_p[c]) + 64'(noise_reg[2*c]);
        if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
        den = pp + 64'(noise_reg[2*c+1]);
        if (den == 0)
            k = one_v;
        else
            k = ((pp << skf_pkg::VAR_FRAC_BITS) + (den >> 1)) / den;
        d    = m - est_x[c];
        mag  = (d < 0) ? 64'(-d) : 64'(d);
        prod = 128'(k) * 128'(mag) + (128'd1 << (skf_pkg::VAR_FRAC_BITS - 1));
        corr = longint'(prod[skf_pkg::VAR_FRAC_BITS +: 64]);
        if (d < 0) corr = -corr;
        est_x[c] = est_x[c] + corr;
        est_p[c] = 32'(((one_v - k) * pp + (one_v >> 1)) >> skf_pkg::VAR_FRAC_BITS);
    endfunction

    // note an accepted request and queue any result it causes
    function void note_request(skf_pkg::mode_t mode, word_t data);
        word_t  res;
        longint m, t;
        res = '0;
        case (mode)
            skf_pkg::MODE_CLEAR: clear_filters();
            skf_pkg::MODE_SET:
                for (int c = 0; c < 4; c++)
                begin
                    est_x[c]  = longint'(signed'(data[32*c +: 32])) <<< skf_pkg::EST_FRAC_BITS;
                    primed[c] = 1;
                end
            skf_pkg::MODE_UPDATE:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    m = longint'(signed'(data[32*c +: 32])) <<< skf_pkg::EST_FRAC_BITS;
                    filter_channel(c, m);
                    t = (est_x[c] + (longint'(1) << (skf_pkg::EST_FRAC_BITS - 1)))
                        >>> skf_pkg::EST_FRAC_BITS;
                    res[32*c +: 32] = t[31:0];
                end
                res[128 +: 48] = data[128 +: 48];
                pending_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // compare a result field by field with the oldest expectation
    function void check_result(word_t got);
        word_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        for (int f = 0; f < 4; f++)
            if (got[32*f +: 32] !== want[32*f +: 32])
            begin
                $display("%0t: estimate %0d expected %0d actual %0d", $realtime, f,
                         $signed(want[32*f +: 32]), $signed(got[32*f +: 32]));
                errors++;
            end
        if (got[128 +: 16] !== want[128 +: 16])
        begin
            $display("%0t: course expected %h actual %h", $realtime,
                     want[128 +: 16], got[128 +: 16]);
            errors++;
        end
        if (got[144 +: 32] !== want[144 +: 32])
        begin
            $display("%0t: stamp expected %h actual %h", $realtime,
                     want[144 +: 32], got[144 +: 32]);
            errors++;
        end
    endfunction
endclass

module tb;
    import skf_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_W-1:0]    cfg_data;

    kalman_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               meas_base [4];

    scalar_kalman_four_channel_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, check on each accepted result
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // send one request, holding valid until it is taken
    task automatic send_request(mode_t mode, logic [31:0] lat, logic [31:0] lon,
                                logic [31:0] alt, logic [31:0] spd,
                                logic [15:0] course, logic [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {stamp, course, spd, alt, lon, lat};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(mode, s_tdata);
        @(negedge clk);
    endtask

    // drain outstanding results, then allow for a request still in flight
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_noise(int idx, logic [31:0] val);
        cfg_we   = 1'b1;
        cfg_addr = CFG_AW'(idx);
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // one random measurement: mostly a noisy walk, sometimes any value
    function automatic logic [31:0] pick_meas(int c);
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:
            begin
                meas_base[c] += int'($urandom_range(2000)) - 1000;
                return meas_base[c] + int'($urandom_range(200)) - 100;
            end
        endcase
    endfunction

    // random traffic, mostly updates with a few sets, clears and ignored modes
    task automatic random_traffic(int count);
        int    sel;
        mode_t mode;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 84)      mode = MODE_UPDATE;
            else if (sel < 92) mode = MODE_SET;
            else if (sel < 97) mode = MODE_CLEAR;
            else               mode = MODE_NONE;
            if (mode == MODE_SET || $urandom_range(49) == 0)
                foreach (meas_base[c]) meas_base[c] = $urandom;
            send_request(mode, pick_meas(0), pick_meas(1), pick_meas(2), pick_meas(3),
                         16'($urandom), $urandom);
        end
    endtask

    task automatic load_noise(int kind);
        for (int i = 0; i < NUM_REGS; i++)
            case (kind)
                0: write_noise(i, 32'd0);
                1: write_noise(i, 32'hFFFF_FFFF);
                2: write_noise(i, $urandom);
                3: write_noise(i, $urandom_range(1 << 24));
                default: write_noise(i, CFG_RESET[i]);
            endcase
    endtask

    // main sequence
    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = MODE_UPDATE;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (meas_base[c]) meas_base[c] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first fix taken as is, extremes, set, ignored mode, clear
        send_request(MODE_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF,
                     16'hFFFF, 32'hFFFF_FFFF);
        send_request(MODE_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd0,
                     16'h0000, 32'h0000_0000);
        send_request(MODE_UPDATE, 32'd100, 32'd100, 32'd100, 32'd100, 16'h5A5A, 32'h1234);
        send_request(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0,
                     16'd0, 32'd0);
        send_request(MODE_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd2,
                     16'hA5A5, 32'h8765_4321);
        send_request(MODE_NONE, 32'd5, 32'd5, 32'd5, 32'd5, 16'd1, 32'd1);
        send_request(MODE_UPDATE, 32'd7, 32'd7, 32'd7, 32'd7, 16'd2, 32'd2);
        send_request(MODE_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        send_request(MODE_UPDATE, 32'd9, 32'hFFFF_FFF7, 32'd9, 32'd9, 16'd3, 32'd3);
        send_request(MODE_UPDATE, 32'd10, 32'hFFFF_FFF6, 32'd10, 32'd10, 16'd4, 32'd4);
        wait_idle();

        // zero noise: gain one, then zero denominator
        load_noise(0);
        send_request(MODE_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0);
        for (int i = 0; i < 4; i++)
            send_request(MODE_UPDATE, $urandom, $urandom, $urandom, $urandom,
                         16'($urandom), $urandom);
        wait_idle();

        // full-scale noise: saturating variance
        load_noise(1);
        for (int i = 0; i < 4; i++)
            send_request(MODE_UPDATE, $urandom, $urandom, $urandom, $urandom,
                         16'($urandom), $urandom);
        wait_idle();

        // random phases across noise settings and idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            load_noise(ph % 5);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            random_traffic(185);
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== scalar_kalman_four_channel_top.f =====
rtl/skf_pkg.sv
rtl/skf_div.sv
rtl/skf_dp.sv
rtl/skf_ctrl.sv
rtl/scalar_kalman_four_channel_top.sv
tb/tb.sv
